// ----- rtl/core/ralf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ralf_pkg
// Shared types, register indexes and level decode tables for the risk alarm
// level state machine.
// ----------------------------------------------------------------------------
package ralf_pkg;

	localparam int RISK_W   = 16;
	localparam int SYM_W    = 3;
	localparam int STAY_W   = 8;
	localparam int N_THR    = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int UPLOAD_W = 16;
	localparam int QOS_W    = 2;
	localparam int BUZZ_W   = 11;

	typedef logic signed [RISK_W-1:0] risk_t;
	typedef logic [SYM_W-1:0]         sym_t;
	typedef logic [STAY_W-1:0]        stay_t;

	typedef enum logic [2:0] {
		LVL_IDLE       = 3'd0,
		LVL_MONITOR    = 3'd1,
		LVL_ALERT_LOW  = 3'd2,
		LVL_ALERT_HIGH = 3'd3,
		LVL_CRITICAL   = 3'd4,
		LVL_FAULT      = 3'd5
	} level_t;

	localparam sym_t SYM_LOW    = 3'd0;
	localparam sym_t SYM_MID    = 3'd1;
	localparam sym_t SYM_ELEV   = 3'd2;
	localparam sym_t SYM_HIGH   = 3'd3;
	localparam sym_t SYM_SEVERE = 3'd4;
	localparam sym_t SYM_FAULT  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_THR0       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR1       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR2       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THR3       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STAY_LIMIT = 3'd4;

	localparam risk_t THR0_RST = 16'sd1638;
	localparam risk_t THR1_RST = 16'sd3277;
	localparam risk_t THR2_RST = 16'sd4915;
	localparam risk_t THR3_RST = 16'sd6554;
	localparam stay_t STAY_LIMIT_RST = 8'd5;

	typedef struct packed {
		logic [BUZZ_W-1:0]   buzzer_hz;
		logic [QOS_W-1:0]    qos_level;
		logic [UPLOAD_W-1:0] upload_interval_ms;
		logic                forced;
		sym_t                symbol;
		logic                changed;
		level_t              prior_level;
		level_t              level;
	} result_t;

	function automatic level_t next_level(level_t cur, sym_t sym);
		level_t nxt;
		case (sym)
			SYM_LOW:    nxt = (cur inside {LVL_ALERT_LOW, LVL_ALERT_HIGH, LVL_CRITICAL})
				? LVL_MONITOR : LVL_IDLE;
			SYM_MID:    nxt = LVL_MONITOR;
			SYM_ELEV:   nxt = LVL_ALERT_LOW;
			SYM_HIGH:   nxt = LVL_ALERT_HIGH;
			SYM_SEVERE: nxt = LVL_CRITICAL;
			SYM_FAULT:  nxt = LVL_FAULT;
			default:    nxt = LVL_IDLE;
		endcase
		return nxt;
	endfunction

	function automatic logic [UPLOAD_W-1:0] upload_ms(level_t lvl);
		logic [UPLOAD_W-1:0] v;
		case (lvl)
			LVL_MONITOR:    v = 16'd30000;
			LVL_ALERT_LOW:  v = 16'd15000;
			LVL_ALERT_HIGH: v = 16'd5000;
			LVL_CRITICAL:   v = 16'd15000;
			LVL_FAULT:      v = 16'd10000;
			default:        v = 16'd60000;
		endcase
		return v;
	endfunction

	function automatic logic [QOS_W-1:0] qos_of(level_t lvl);
		logic [QOS_W-1:0] v;
		case (lvl)
			LVL_ALERT_HIGH: v = 2'd1;
			LVL_CRITICAL:   v = 2'd2;
			LVL_FAULT:      v = 2'd1;
			default:        v = 2'd0;
		endcase
		return v;
	endfunction

	function automatic logic [BUZZ_W-1:0] buzzer_of(level_t lvl);
		logic [BUZZ_W-1:0] v;
		case (lvl)
			LVL_ALERT_LOW:  v = 11'd500;
			LVL_ALERT_HIGH: v = 11'd1000;
			LVL_CRITICAL:   v = 11'd2000;
			default:        v = 11'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ralf_symbolize.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ralf_symbolize
// Reduce a risk sample and fault flag to a symbol: fault first, then the
// lowest-indexed threshold that the sample falls below.
// ----------------------------------------------------------------------------
module ralf_symbolize (
	input  var ralf_pkg::risk_t risk,
	input  var logic            fault_flag,
	input  var ralf_pkg::risk_t thr [ralf_pkg::N_THR],
	output ralf_pkg::sym_t      symbol
);

	always_comb begin
		if (fault_flag) begin
			symbol = ralf_pkg::SYM_FAULT;
		end else begin
			symbol = ralf_pkg::SYM_SEVERE;
			for (int i = ralf_pkg::N_THR - 1; i >= 0; i--) begin
				if (risk < thr[i]) begin
					symbol = ralf_pkg::SYM_W'(i);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/ralf_level_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ralf_level_step
// Level state, stay counter and prior level; computes the next level and the
// decoded result for one symbol, and commits the state on advance.
// ----------------------------------------------------------------------------
module ralf_level_step (
	input  var logic               clk,
	input  var logic               arst_n,
	input  var logic               advance,
	input  var ralf_pkg::sym_t     symbol,
	input  var ralf_pkg::stay_t    stay_limit,
	output ralf_pkg::result_t      result
);

	ralf_pkg::level_t level_q;
	ralf_pkg::level_t prior_q;
	ralf_pkg::stay_t  stay_q;

	ralf_pkg::level_t tab_nxt;
	ralf_pkg::level_t nxt;
	ralf_pkg::level_t prior_d;
	ralf_pkg::stay_t  stay_inc;
	ralf_pkg::stay_t  stay_d;
	logic             hold;
	logic             hit;
	logic             chg;

	always_comb begin
		tab_nxt  = ralf_pkg::next_level(level_q, symbol);
		hold     = (tab_nxt == level_q) &&
			(level_q == ralf_pkg::LVL_ALERT_HIGH || level_q == ralf_pkg::LVL_CRITICAL);
		stay_inc = stay_q + ralf_pkg::STAY_W'(1);
		hit      = hold && (stay_inc >= stay_limit);
		nxt      = hit ? ralf_pkg::LVL_CRITICAL : tab_nxt;
		stay_d   = (hold && !hit) ? stay_inc : '0;
		chg      = (nxt != level_q);
		prior_d  = chg ? level_q : prior_q;

		result.level              = nxt;
		result.prior_level        = prior_d;
		result.changed            = chg;
		result.symbol             = symbol;
		result.forced             = hit;
		result.upload_interval_ms = ralf_pkg::upload_ms(nxt);
		result.qos_level          = ralf_pkg::qos_of(nxt);
		result.buzzer_hz          = ralf_pkg::buzzer_of(nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= ralf_pkg::LVL_IDLE;
			prior_q <= ralf_pkg::LVL_IDLE;
			stay_q  <= '0;
		end else if (advance) begin
			level_q <= nxt;
			prior_q <= prior_d;
			stay_q  <= stay_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/risk_alarm_level_fsm.sv -----
`default_nettype none
// A sample is taken into the input register; when it advances, its result word
// is registered in the output register and offered on the master port from there.
// Throughput: one sample per cycle while the output is not held; while a result
// waits downstream the input register takes one more word, then the input stalls.
// Reset: level and prior level return to idle, the stay count clears and the
// thresholds and stay limit take their defaults; no clearing pass.
// ----------------------------------------------------------------------------
// risk_alarm_level_fsm
// Risk sample classifier and alarm level state machine with stream ports and
// a register write channel.
// ----------------------------------------------------------------------------
module risk_alarm_level_fsm (
	input  var logic                                clk,
	input  var logic                                arst_n,
	input  var logic                                cfg_valid,
	output logic                                    cfg_ready,
	input  var logic [ralf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  var logic [ralf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  var logic                                s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  var logic [15:0]                         s_axis_tdata,  // risk[15:0]
	input  var logic                                s_axis_tuser,  // fault_flag
	output logic                                    m_axis_tvalid,
	input  var logic                                m_axis_tready,
	// level[2:0], prior_level[5:3], changed[6], symbol[9:7], forced[10],
	// upload_interval_ms[26:11], qos_level[28:27], buzzer_hz[39:29]
	output logic [39:0]                             m_axis_tdata
);

	ralf_pkg::risk_t   thr_q [ralf_pkg::N_THR];
	ralf_pkg::stay_t   stay_limit_q;

	logic              vld_s1;
	ralf_pkg::risk_t   risk_s1;
	logic              fault_s1;
	logic              vld_s2;
	ralf_pkg::result_t res_s2;

	ralf_pkg::sym_t    symbol;
	ralf_pkg::result_t result;
	logic              advance;

	assign cfg_ready     = 1'b1;
	assign advance       = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;
	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q[0]     <= ralf_pkg::THR0_RST;
			thr_q[1]     <= ralf_pkg::THR1_RST;
			thr_q[2]     <= ralf_pkg::THR2_RST;
			thr_q[3]     <= ralf_pkg::THR3_RST;
			stay_limit_q <= ralf_pkg::STAY_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ralf_pkg::CFG_THR0, ralf_pkg::CFG_THR1,
				ralf_pkg::CFG_THR2, ralf_pkg::CFG_THR3: begin
					thr_q[cfg_index[1:0]] <= ralf_pkg::risk_t'(cfg_data);
				end
				ralf_pkg::CFG_STAY_LIMIT: begin
					stay_limit_q <= cfg_data[ralf_pkg::STAY_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				vld_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			risk_s1  <= s_axis_tdata;
			fault_s1 <= s_axis_tuser;
		end
		if (advance) begin
			res_s2 <= result;
		end
	end

	ralf_symbolize u_symbolize (
		.risk       (risk_s1),
		.fault_flag (fault_s1),
		.thr        (thr_q),
		.symbol     (symbol)
	);

	ralf_level_step u_level_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.symbol     (symbol),
		.stay_limit (stay_limit_q),
		.result     (result)
	);

`ifndef NO_ASSERTIONS
	a_forced_critical: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.forced |-> res_s2.level == ralf_pkg::LVL_CRITICAL)
		else $error("forced result without critical level");

	a_changed_prior: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.changed |-> res_s2.level != res_s2.prior_level)
		else $error("changed result with level equal to prior level");

	a_fault_level: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.symbol == ralf_pkg::SYM_FAULT |->
			res_s2.level == ralf_pkg::LVL_FAULT && !res_s2.forced)
		else $error("fault symbol did not give fault level");

	a_result_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> vld_s2 && res_s2 == $past(result))
		else $error("result register missed an advancing word");
`endif

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the risk alarm level state machine. Sends risk samples
// and fault flags through the slave port, writes thresholds and the stay limit
// through the register channel, predicts each result word from a behavioral
// copy of the classifier and level machine, and compares every field of each
// word on the master port. Idle gaps and output stalls come at random.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ralf_pkg::*;

	localparam int    WATCHDOG_LIMIT = 3000;
	localparam int    SETTLE_CYCLES  = 4;
	localparam risk_t RISK_MIN       = 16'sh8000;
	localparam risk_t RISK_MAX       = 16'sh7FFF;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [39:0]           m_axis_tdata;

	// alarm machine copy
	risk_t   mdl_thr [N_THR];
	stay_t   mdl_limit;
	level_t  mdl_level;
	level_t  mdl_prior;
	stay_t   mdl_stay;
	result_t expected_alarms [$];

	bit src_gaps = 1'b1;
	bit sink_stalls = 1'b1;
	int sink_hold_cycles = 0;
	int mismatches = 0;
	int n_samples = 0;
	int n_results = 0;
	int n_writes = 0;
	int n_forced = 0;
	int quiet_cycles = 0;

	risk_alarm_level_fsm uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic sym_t classify_risk(risk_t r, logic fault);
		if (fault)
			return SYM_FAULT;
		for (int i = 0; i < N_THR; i++)
			if (r < mdl_thr[i])
				return sym_t'(i);
		return SYM_SEVERE;
	endfunction

	function automatic logic [UPLOAD_W-1:0] period_for(level_t l);
		case (l)
			LVL_MONITOR:    return 16'd30000;
			LVL_ALERT_LOW:  return 16'd15000;
			LVL_ALERT_HIGH: return 16'd5000;
			LVL_CRITICAL:   return 16'd15000;
			LVL_FAULT:      return 16'd10000;
			default:        return 16'd60000;
		endcase
	endfunction

	function automatic logic [QOS_W-1:0] delivery_for(level_t l);
		case (l)
			LVL_CRITICAL:                return 2'd2;
			LVL_ALERT_HIGH, LVL_FAULT:   return 2'd1;
			default:                     return 2'd0;
		endcase
	endfunction

	function automatic logic [BUZZ_W-1:0] tone_for(level_t l);
		case (l)
			LVL_ALERT_LOW:  return 11'd500;
			LVL_ALERT_HIGH: return 11'd1000;
			LVL_CRITICAL:   return 11'd2000;
			default:        return 11'd0;
		endcase
	endfunction

	task automatic predict_alarm_step(input risk_t r, input logic fault, output result_t w);
		level_t cur;
		level_t nxt;
		sym_t   sym;
		logic   forced;
		sym = classify_risk(r, fault);
		cur = mdl_level;
		forced = 1'b0;
		case (sym)
			SYM_LOW: begin
				nxt = (cur == LVL_ALERT_LOW || cur == LVL_ALERT_HIGH || cur == LVL_CRITICAL)
					? LVL_MONITOR : LVL_IDLE;
			end
			default: nxt = level_t'(sym);
		endcase
		if (nxt == cur && (cur == LVL_ALERT_HIGH || cur == LVL_CRITICAL)) begin
			mdl_stay = mdl_stay + 1'b1;
			if (mdl_stay >= mdl_limit) begin
				mdl_stay = '0;
				nxt = LVL_CRITICAL;
				forced = 1'b1;
			end
		end else begin
			mdl_stay = '0;
		end
		w.changed = (nxt != cur);
		if (nxt != cur) begin
			mdl_prior = cur;
			mdl_level = nxt;
		end
		w.level = mdl_level;
		w.prior_level = mdl_prior;
		w.symbol = sym;
		w.forced = forced;
		w.upload_interval_ms = period_for(mdl_level);
		w.qos_level = delivery_for(mdl_level);
		w.buzzer_hz = tone_for(mdl_level);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mdl_thr[0] = THR0_RST;
			mdl_thr[1] = THR1_RST;
			mdl_thr[2] = THR2_RST;
			mdl_thr[3] = THR3_RST;
			mdl_limit = STAY_LIMIT_RST;
			mdl_level = LVL_IDLE;
			mdl_prior = LVL_IDLE;
			mdl_stay = '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_THR0, CFG_THR1, CFG_THR2, CFG_THR3:
					mdl_thr[cfg_index[1:0]] = risk_t'(cfg_data);
				CFG_STAY_LIMIT: mdl_limit = cfg_data[STAY_W-1:0];
				default: ;
			endcase
			n_writes++;
		end
	end

	always @(posedge clk) begin : track_samples
		result_t w;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			predict_alarm_step(risk_t'(s_axis_tdata), s_axis_tuser, w);
			expected_alarms.push_back(w);
			n_samples++;
			if (w.forced)
				n_forced++;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch on result %0d: %s got %0d want %0d", n_results, what, got, want);
	endtask

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			n_results++;
			if (expected_alarms.size() == 0) begin
				report_mismatch("unexpected word, tdata", got, 0);
			end else begin
				want = expected_alarms.pop_front();
				if (got.level !== want.level)
					report_mismatch("level", got.level, want.level);
				if (got.prior_level !== want.prior_level)
					report_mismatch("prior_level", got.prior_level, want.prior_level);
				if (got.changed !== want.changed)
					report_mismatch("changed", got.changed, want.changed);
				if (got.symbol !== want.symbol)
					report_mismatch("symbol", got.symbol, want.symbol);
				if (got.forced !== want.forced)
					report_mismatch("forced", got.forced, want.forced);
				if (got.upload_interval_ms !== want.upload_interval_ms)
					report_mismatch("upload_interval_ms", got.upload_interval_ms,
						want.upload_interval_ms);
				if (got.qos_level !== want.qos_level)
					report_mismatch("qos_level", got.qos_level, want.qos_level);
				if (got.buzzer_hz !== want.buzzer_hz)
					report_mismatch("buzzer_hz", got.buzzer_hz, want.buzzer_hz);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", quiet_cycles);
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin : sink_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (sink_hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				stall_left = sink_hold_cycles - 1;
				sink_hold_cycles = 0;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(0, 8);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_word(input risk_t r, input logic fault);
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= r;
		s_axis_tuser <= fault;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_alarms.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_alarm_config(input risk_t t0, input risk_t t1, input risk_t t2,
			input risk_t t3, input stay_t lim);
		drain_results();
		write_reg(CFG_THR0, t0);
		write_reg(CFG_THR1, t1);
		write_reg(CFG_THR2, t2);
		write_reg(CFG_THR3, t3);
		// upper byte of the stay limit write is don't-care
		write_reg(CFG_STAY_LIMIT, {8'($urandom), lim});
		cfg_valid <= 1'b0;
	endtask

	function automatic risk_t band_risk(sym_t s);
		int lo;
		int hi;
		lo = (s == SYM_LOW) ? -32768 : int'(mdl_thr[s - 1]);
		hi = (s == SYM_SEVERE) ? 32767 : int'(mdl_thr[s]) - 1;
		if (lo > hi)
			return risk_t'($urandom);
		return risk_t'(lo + int'($urandom_range(hi - lo)));
	endfunction

	task automatic run_episodes(input int n_items, input int noise_pct);
		int   sent;
		int   len;
		sym_t s;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				send_word(risk_t'($urandom), $urandom_range(0, 3) == 0);
				sent++;
			end else begin
				s = sym_t'($urandom_range(SYM_LOW, SYM_FAULT));
				len = $urandom_range(1, int'(mdl_limit) + 2);
				if (len > 12)
					len = 12;
				repeat (len) begin
					if (s == SYM_FAULT)
						send_word(risk_t'($urandom), 1'b1);
					else
						send_word(band_risk(s), 1'b0);
					sent++;
				end
			end
		end
	endtask

	task automatic test_directed_walk();
		risk_t walk_risk [24];
		logic  walk_fault [24];
		walk_risk = '{RISK_MIN, THR0_RST - 16'sd1, THR0_RST, THR1_RST, 16'sd0, THR2_RST,
			THR3_RST - 16'sd1, THR3_RST - 16'sd1, THR3_RST - 16'sd1, THR3_RST - 16'sd1,
			THR3_RST - 16'sd1, THR3_RST, RISK_MAX, RISK_MAX, RISK_MAX, RISK_MAX,
			-16'sd1, 16'sd0, RISK_MAX, RISK_MIN, 16'sd0, RISK_MAX, RISK_MIN, RISK_MIN};
		walk_fault = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			0, 1, 1, 1, 0, 0, 0, 0};
		for (int i = 0; i < 24; i++)
			send_word(walk_risk[i], walk_fault[i]);
	endtask

	task automatic test_threshold_orders();
		set_alarm_config(RISK_MIN, RISK_MIN, RISK_MIN, RISK_MIN, STAY_LIMIT_RST);
		send_word(RISK_MIN, 1'b0);
		repeat (12) send_word(risk_t'($urandom), $urandom_range(0, 7) == 0);
		set_alarm_config(RISK_MAX, RISK_MAX, RISK_MAX, RISK_MAX, STAY_LIMIT_RST);
		send_word(RISK_MAX, 1'b0);
		send_word(RISK_MAX - 16'sd1, 1'b0);
		repeat (12) send_word(risk_t'($urandom), $urandom_range(0, 7) == 0);
		// out of order: the first threshold that holds decides
		set_alarm_config(16'sd10000, -16'sd10000, 16'sd20000, 16'sd0, 8'd3);
		send_word(16'sd9999, 1'b0);
		send_word(16'sd15000, 1'b0);
		send_word(16'sd25000, 1'b0);
		repeat (12) send_word(risk_t'($urandom), $urandom_range(0, 7) == 0);
	endtask

	task automatic test_stay_limits();
		set_alarm_config(THR0_RST, THR1_RST, THR2_RST, THR3_RST, 8'd1);
		run_episodes(20, 0);
		set_alarm_config(THR0_RST, THR1_RST, THR2_RST, THR3_RST, 8'd0);
		run_episodes(20, 0);
		set_alarm_config(THR0_RST, THR1_RST, THR2_RST, THR3_RST, 8'd255);
		repeat (260) send_word(band_risk(SYM_SEVERE), 1'b0);
		send_word(band_risk(SYM_LOW), 1'b0);
		// spare indexes must not disturb anything
		drain_results();
		for (int i = CFG_STAY_LIMIT + 1; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), 16'($urandom));
		cfg_valid <= 1'b0;
		run_episodes(15, 20);
	endtask

	task automatic test_random_episodes();
		int bounds [$];
		for (int round = 0; round < 4; round++) begin
			bounds.delete();
			repeat (N_THR) begin
				if (round[0])
					bounds.push_back(int'($urandom_range(0, 12000)) - 4000);
				else
					bounds.push_back(int'(risk_t'($urandom)));
			end
			bounds.sort();
			set_alarm_config(risk_t'(bounds[0]), risk_t'(bounds[1]), risk_t'(bounds[2]),
				risk_t'(bounds[3]), stay_t'($urandom_range(1, 8)));
			run_episodes(25, 15);
		end
	endtask

	task automatic test_backpressure();
		set_alarm_config(THR0_RST, THR1_RST, THR2_RST, THR3_RST, STAY_LIMIT_RST);
		src_gaps = 1'b0;
		sink_hold_cycles = 60;
		run_episodes(25, 10);
		src_gaps = 1'b1;
		// hold input until every result is back
		drain_results();
		run_episodes(10, 10);
	endtask

	task automatic test_quiet_tail();
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		run_episodes(40, 20);
	endtask

	initial begin : main
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_walk();
		test_threshold_orders();
		test_stay_limits();
		test_random_episodes();
		test_backpressure();
		test_quiet_tail();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run: %0d samples, %0d result words, %0d forced escalations, %0d register writes",
			n_samples, n_results, n_forced, n_writes);
		$display("run: default, clamped and out-of-order thresholds, stay limits 0/1/255,");
		$display("     faults, long output hold");
		if (mismatches == 0 && expected_alarms.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
